/* design/jsu_pkg.sv */
// Package for the JSON string unescaper: decode modes, status codes,
// character codes, the burst record and the UTF-8 encoding helpers.
// No dependencies.
`timescale 1ns / 1ps

package jsu_pkg;

  // Burst queue between the decoder and the result port
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);
  localparam int MAXB   = 6;  // most bytes one input can cause

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_ESC,
    MODE_HEX1,
    MODE_PEND,
    MODE_PEND_ESC,
    MODE_HEX2
  } mode_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_CLOSED,
    ST_UNTERM
  } status_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LC_U   = 8'h75;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_FHI = 8'h66;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_F   = 8'h46;

  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_CR = 8'h0D;
  localparam logic [7:0] CTL_HT = 8'h09;
  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0C;

  localparam logic [15:0] SURR_HI_MIN = 16'hD800;
  localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
  localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
  localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;

  // One code point (or raw byte) as up to four bytes, first byte in [0]
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
  } enc_t;

  // All results of one input item
  typedef struct packed {
    logic [MAXB-1:0][7:0] bytes;
    logic [2:0]           len;
    status_t              status;
  } burst_t;

  function automatic enc_t enc_raw(input logic [7:0] b);
    enc_t e;
    e = '0;
    e.bytes[0] = b;
    e.len = 3'd1;
    return e;
  endfunction

  function automatic enc_t enc_cp(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp < 21'h80) begin
      e.bytes[0] = cp[7:0];
      e.len = 3'd1;
    end else if (cp < 21'h800) begin
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
      e.len = 3'd2;
    end else if (cp < 21'h10000) begin
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
      e.len = 3'd3;
    end else begin
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
      e.len = 3'd4;
    end
    return e;
  endfunction

  // {is_digit, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      r = {1'b1, 4'(b - CH_ZERO)};
    end else if (b >= CH_LC_A && b <= CH_LC_FHI) begin
      r = {1'b1, 4'(b - CH_LC_A + 8'd10)};
    end else if (b >= CH_UC_A && b <= CH_UC_F) begin
      r = {1'b1, 4'(b - CH_UC_A + 8'd10)};
    end
    return r;
  endfunction

  // Byte that a backslash escape stands for (not \u)
  function automatic logic [7:0] esc_map(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    case (b)
      CH_LC_N: r = CTL_LF;
      CH_LC_R: r = CTL_CR;
      CH_LC_T: r = CTL_HT;
      CH_LC_B: r = CTL_BS;
      CH_LC_F: r = CTL_FF;
      default: r = b;
    endcase
    return r;
  endfunction

  function automatic logic is_high_surr(input logic [15:0] v);
    return (v >= SURR_HI_MIN) && (v <= SURR_HI_MAX);
  endfunction

  function automatic logic is_low_surr(input logic [15:0] v);
    return (v >= SURR_LO_MIN) && (v <= SURR_LO_MAX);
  endfunction

endpackage

/* design/jsu_in_if.sv */
// Input channel of the JSON string unescaper: valid/ready plus one text byte.
// Depends on nothing.
`timescale 1ns / 1ps

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_buffer;

  modport source (output valid, output in_byte, output end_of_buffer, input ready);
  modport sink (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

/* design/jsu_out_if.sv */
// Result channel of the JSON string unescaper: valid/ready plus one result.
// Depends on jsu_pkg for the status type.
`timescale 1ns / 1ps

interface jsu_out_if;
  logic             valid;
  logic             ready;
  logic [7:0]       out_byte;
  logic             byte_valid;
  jsu_pkg::status_t status;
  logic             last_of_run;

  modport source (output valid, output out_byte, output byte_valid, output status,
                  output last_of_run, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input status,
                input last_of_run, output ready);
endinterface

/* design/json_string_unescape_utf8.sv */
// JSON string body unescaper with UTF-8 output. Feed the bytes that follow the
// opening quote on in_ch; decoded bytes come out on out_ch, one per request,
// with last_of_run marking the final result of each input byte and status set
// on the result that closes the string (quote or end of buffer). One input
// byte is taken per cycle; its results are queued on acceptance and drain at
// one per cycle while out_ch.ready is high. An input byte causes up to six
// results (a broken surrogate pair), so a 4-entry burst queue sits between
// the decoder and the output; in_ch.ready drops only while that queue is
// full. After the string closes, input is accepted and dropped until reset.
// Depends on jsu_pkg, jsu_in_if and jsu_out_if.
`timescale 1ns / 1ps

module json_string_unescape_utf8 (
  input  logic          clk,
  input  logic          rst_n,
  jsu_in_if.sink        in_ch,
  jsu_out_if.source     out_ch
);
  import jsu_pkg::*;

  // decoder state
  mode_t       mode_r, mode_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        stop_r, stop_nxt;
  logic [15:0] pend_r, pend_nxt;
  logic        fin_r, fin_nxt;

  // burst queue
  burst_t          q_r [QDEPTH];
  logic [QAW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]  qcnt_r;
  logic [2:0]      idx_r;

  logic        in_acc, out_acc, push, pop, last;
  logic [4:0]  hd;
  logic [15:0] hacc;
  logic        hstop, hdone;
  logic [20:0] pair_cp;
  enc_t        ua, ub;
  logic        ua_v, ub_v;
  status_t     st;
  burst_t      burst;
  burst_t      head;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  // hex group step
  assign hd      = hex_digit(in_ch.in_byte);
  assign hacc    = (!stop_r && hd[4]) ? {acc_r[11:0], hd[3:0]} : acc_r;
  assign hstop   = stop_r | ~hd[4];
  assign hdone   = (cnt_r == 3'd3);
  assign pair_cp = SUPP_BASE + {1'b0, pend_r[9:0], hacc[9:0]};

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    stop_nxt = stop_r;
    pend_nxt = pend_r;
    fin_nxt  = fin_r;
    ua   = '0;
    ub   = '0;
    ua_v = 1'b0;
    ub_v = 1'b0;
    st   = ST_RUN;
    if (!fin_r) begin
      unique case (mode_r)
        MODE_ESC: begin
          mode_nxt = MODE_NORMAL;
          if (in_ch.in_byte == CH_LC_U) begin
            mode_nxt = MODE_HEX1;
            acc_nxt  = '0;
            cnt_nxt  = '0;
            stop_nxt = 1'b0;
          end else begin
            ua   = enc_raw(esc_map(in_ch.in_byte));
            ua_v = 1'b1;
          end
        end
        MODE_HEX1: begin
          acc_nxt  = hacc;
          stop_nxt = hstop;
          cnt_nxt  = cnt_r + 3'd1;
          if (hdone) begin
            if (is_high_surr(hacc)) begin
              pend_nxt = hacc;
              mode_nxt = MODE_PEND;
            end else begin
              ua       = enc_cp({5'b0, hacc});
              ua_v     = 1'b1;
              mode_nxt = MODE_NORMAL;
            end
          end
        end
        MODE_PEND: begin
          if (in_ch.in_byte == CH_BSLASH) begin
            mode_nxt = MODE_PEND_ESC;
          end else begin
            ua       = enc_cp({5'b0, pend_r});
            ua_v     = 1'b1;
            mode_nxt = MODE_NORMAL;
            if (in_ch.in_byte == CH_QUOTE) begin
              st = ST_CLOSED;
            end else begin
              ub   = enc_raw(in_ch.in_byte);
              ub_v = 1'b1;
            end
          end
        end
        MODE_PEND_ESC: begin
          if (in_ch.in_byte == CH_LC_U) begin
            mode_nxt = MODE_HEX2;
            acc_nxt  = '0;
            cnt_nxt  = '0;
            stop_nxt = 1'b0;
          end else begin
            ua       = enc_cp({5'b0, pend_r});
            ua_v     = 1'b1;
            ub       = enc_raw(esc_map(in_ch.in_byte));
            ub_v     = 1'b1;
            mode_nxt = MODE_NORMAL;
          end
        end
        MODE_HEX2: begin
          acc_nxt  = hacc;
          stop_nxt = hstop;
          cnt_nxt  = cnt_r + 3'd1;
          if (hdone) begin
            if (is_low_surr(hacc)) begin
              ua       = enc_cp(pair_cp);
              ua_v     = 1'b1;
              mode_nxt = MODE_NORMAL;
            end else begin
              ua   = enc_cp({5'b0, pend_r});
              ua_v = 1'b1;
              if (is_high_surr(hacc)) begin
                pend_nxt = hacc;
                mode_nxt = MODE_PEND;
              end else begin
                ub       = enc_cp({5'b0, hacc});
                ub_v     = 1'b1;
                mode_nxt = MODE_NORMAL;
              end
            end
          end
        end
        default: begin
          mode_nxt = MODE_NORMAL;
          if (in_ch.in_byte == CH_QUOTE) begin
            st = ST_CLOSED;
          end else if (in_ch.in_byte == CH_BSLASH) begin
            mode_nxt = MODE_ESC;
          end else begin
            ua   = enc_raw(in_ch.in_byte);
            ua_v = 1'b1;
          end
        end
      endcase

      // end of buffer flushes a held high surrogate
      if (st == ST_RUN && in_ch.end_of_buffer) begin
        if (mode_nxt == MODE_PEND || mode_nxt == MODE_PEND_ESC ||
            mode_nxt == MODE_HEX2) begin
          if (!ua_v) begin
            ua   = enc_cp({5'b0, pend_nxt});
            ua_v = 1'b1;
          end else begin
            ub   = enc_cp({5'b0, pend_nxt});
            ub_v = 1'b1;
          end
        end
        st = ST_UNTERM;
      end
      if (st != ST_RUN) begin
        fin_nxt  = 1'b1;
        mode_nxt = MODE_NORMAL;
      end
    end
  end

  // pack both pieces into one burst
  always_comb begin
    logic [2:0] la, lb, iv, jv;
    la = ua_v ? ua.len : 3'd0;
    lb = ub_v ? ub.len : 3'd0;
    burst        = '0;
    burst.len    = la + lb;
    burst.status = st;
    for (int i = 0; i < MAXB; i++) begin
      iv = 3'(i);
      jv = iv - la;
      if (iv < la) begin
        burst.bytes[i] = ua.bytes[iv[1:0]];
      end else if (jv < lb) begin
        burst.bytes[i] = ub.bytes[jv[1:0]];
      end
    end
  end

  assign push = in_acc && !fin_r && (burst.len != 3'd0 || st != ST_RUN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      acc_r  <= '0;
      cnt_r  <= '0;
      stop_r <= 1'b0;
      pend_r <= '0;
      fin_r  <= 1'b0;
    end else if (in_acc) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      stop_r <= stop_nxt;
      pend_r <= pend_nxt;
      fin_r  <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= burst;
    end
  end

  // result side: walk the head burst one byte per request
  assign head = q_r[rd_ptr_r];
  assign last = (head.len == 3'd0) || (idx_r == head.len - 3'd1);
  assign pop  = out_acc && last;

  assign in_ch.ready        = (qcnt_r != QCW'(QDEPTH));
  assign out_ch.valid       = (qcnt_r != '0);
  assign out_ch.byte_valid  = (head.len != 3'd0);
  assign out_ch.out_byte    = (head.len != 3'd0) ? head.bytes[idx_r] : 8'h00;
  assign out_ch.status      = last ? head.status : ST_RUN;
  assign out_ch.last_of_run = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      qcnt_r   <= '0;
      idx_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      qcnt_r <= qcnt_r + QCW'(push) - QCW'(pop);
      if (out_acc) begin
        idx_r <= last ? 3'd0 : idx_r + 3'd1;
      end
    end
  end

endmodule

/* design/jsu_checker.sv */
// Port-level checks for json_string_unescape_utf8, attached by bind.
// Depends on jsu_pkg and the top level's interface ports.
`timescale 1ns / 1ps

module jsu_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [7:0]       out_byte,
  input logic             byte_valid,
  input jsu_pkg::status_t status,
  input logic             last_of_run
);
  import jsu_pkg::*;

  logic closed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      closed_r <= 1'b0;
    end else if (out_valid && out_ready && last_of_run && status != ST_RUN) begin
      closed_r <= 1'b1;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(byte_valid) && $stable(status) && $stable(last_of_run))
    else $error("result changed while stalled");

  a_status_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last_of_run |-> status == ST_RUN)
    else $error("status set before the last result of a run");

  a_empty_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !byte_valid |-> last_of_run && status != ST_RUN)
    else $error("result without a byte that does not close the string");

  a_nothing_after_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !closed_r)
    else $error("result after the string closed");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte    (out_ch.out_byte),
  .byte_valid  (out_ch.byte_valid),
  .status      (out_ch.status),
  .last_of_run (out_ch.last_of_run)
);

/* verif/tb.sv */
// Testbench for json_string_unescape_utf8: streams one JSON string body through
// the block and checks every decoded byte against an in-bench decoder.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if and the block itself.
`timescale 1ns / 1ps

module tb;
  import jsu_pkg::*;

  localparam int STALL_LIMIT = 2000;  // cycles with no request moving
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       bv;
    status_t    st;
    logic       last;
  } res_t;

  logic clk = 1'b0;
  logic rst_n;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescape_utf8 dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  int src_idle_pct = 25;
  int snk_idle_pct = 58;
  int mismatches   = 0;
  int bytes_sent   = 0;
  int idle_cycles  = 0;

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------
  res_t        due_bytes[$];
  logic [7:0]  step_bytes[$];
  mode_t       dec_mode;
  logic [15:0] hex_val;
  logic [2:0]  hex_pos;
  logic        hex_dead;
  logic [15:0] held_high;
  logic        str_closed;

  function automatic void add_byte(input logic [7:0] b);
    step_bytes = {step_bytes, b};
  endfunction

  function automatic int nibble_of(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b) - int'("0");
    if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
    if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
    return 16;
  endfunction

  function automatic void emit_code(input int unsigned cp);
    if (cp < 32'h80) begin
      add_byte(8'(cp));
    end else if (cp < 32'h800) begin
      add_byte(8'(32'hC0 | (cp >> 6)));
      add_byte(8'(32'h80 | (cp & 32'h3F)));
    end else if (cp < 32'h10000) begin
      add_byte(8'(32'hE0 | (cp >> 12)));
      add_byte(8'(32'h80 | ((cp >> 6) & 32'h3F)));
      add_byte(8'(32'h80 | (cp & 32'h3F)));
    end else begin
      add_byte(8'(32'hF0 | (cp >> 18)));
      add_byte(8'(32'h80 | ((cp >> 12) & 32'h3F)));
      add_byte(8'(32'h80 | ((cp >> 6) & 32'h3F)));
      add_byte(8'(32'h80 | (cp & 32'h3F)));
    end
  endfunction

  function automatic void open_hex(input mode_t m);
    dec_mode = m;
    hex_val  = '0;
    hex_pos  = '0;
    hex_dead = 1'b0;
  endfunction

  function automatic void eat_hex(input logic [7:0] b);
    int d;
    d = nibble_of(b);
    if (!hex_dead && d < 16) hex_val = (hex_val << 4) | 16'(d);
    else hex_dead = 1'b1;
    hex_pos = hex_pos + 3'd1;
  endfunction

  function automatic void settle_value(input logic [15:0] v);
    if (v >= SURR_HI_MIN && v <= SURR_HI_MAX) begin
      held_high = v;
      dec_mode  = MODE_PEND;
    end else begin
      emit_code(int'(v));
      dec_mode = MODE_NORMAL;
    end
  endfunction

  function automatic status_t eat_plain(input logic [7:0] b);
    if (b == CH_QUOTE) return ST_CLOSED;
    if (b == CH_BSLASH) dec_mode = MODE_ESC;
    else add_byte(b);
    return ST_RUN;
  endfunction

  function automatic void eat_escape(input logic [7:0] b);
    dec_mode = MODE_NORMAL;
    case (b)
      CH_LC_N: add_byte(CTL_LF);
      CH_LC_R: add_byte(CTL_CR);
      CH_LC_T: add_byte(CTL_HT);
      CH_LC_B: add_byte(CTL_BS);
      CH_LC_F: add_byte(CTL_FF);
      CH_LC_U: open_hex(MODE_HEX1);
      default: add_byte(b);
    endcase
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic eob);
    status_t     st;
    res_t        r;
    int unsigned cp;
    if (str_closed) return;
    step_bytes.delete();
    st = ST_RUN;
    case (dec_mode)
      MODE_ESC: eat_escape(b);
      MODE_HEX1: begin
        eat_hex(b);
        if (hex_pos == 3'd4) settle_value(hex_val);
      end
      MODE_PEND: begin
        if (b == CH_BSLASH) begin
          dec_mode = MODE_PEND_ESC;
        end else begin
          emit_code(int'(held_high));
          dec_mode = MODE_NORMAL;
          st = eat_plain(b);
        end
      end
      MODE_PEND_ESC: begin
        if (b == CH_LC_U) begin
          open_hex(MODE_HEX2);
        end else begin
          emit_code(int'(held_high));
          eat_escape(b);
        end
      end
      MODE_HEX2: begin
        eat_hex(b);
        if (hex_pos == 3'd4) begin
          if (hex_val >= SURR_LO_MIN && hex_val <= SURR_LO_MAX) begin
            cp = 32'h10000 + ((int'(held_high) - 32'hD800) << 10)
                 + (int'(hex_val) - 32'hDC00);
            emit_code(cp);
            dec_mode = MODE_NORMAL;
          end else begin
            emit_code(int'(held_high));
            settle_value(hex_val);
          end
        end
      end
      default: begin
        dec_mode = MODE_NORMAL;
        st = eat_plain(b);
      end
    endcase

    if (st == ST_RUN && eob) begin
      // held high surrogate goes out before the buffer-end status
      if (dec_mode == MODE_PEND || dec_mode == MODE_PEND_ESC || dec_mode == MODE_HEX2)
        emit_code(int'(held_high));
      st = ST_UNTERM;
    end
    if (st != ST_RUN) begin
      str_closed = 1'b1;
      dec_mode   = MODE_NORMAL;
    end

    foreach (step_bytes[k]) begin
      r.data = step_bytes[k];
      r.bv   = 1'b1;
      r.st   = (k == step_bytes.size() - 1) ? st : ST_RUN;
      r.last = (k == step_bytes.size() - 1);
      due_bytes = {due_bytes, r};
    end
    if (st != ST_RUN && step_bytes.size() == 0) begin
      r.data = '0;
      r.bv   = 1'b0;
      r.st   = st;
      r.last = 1'b1;
      due_bytes = {due_bytes, r};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    mismatches++;
    $display("[%0t] mismatch %s: got 0x%02h, expected 0x%02h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    res_t r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_bytes.size() == 0) begin
        report("unexpected result, byte", out_ch.out_byte, 8'h00);
      end else begin
        r = due_bytes.pop_front();
        if (out_ch.out_byte !== r.data) report("out_byte", out_ch.out_byte, r.data);
        if (out_ch.byte_valid !== r.bv) report("byte_valid", 8'(out_ch.byte_valid), 8'(r.bv));
        if (out_ch.status !== r.st) report("status", 8'(out_ch.status), 8'(r.st));
        if (out_ch.last_of_run !== r.last)
          report("last_of_run", 8'(out_ch.last_of_run), 8'(r.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  always @(negedge clk) out_ch.ready <= rst_n && ($urandom_range(99) >= snk_idle_pct);

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Entered and left at a falling edge; valid stays high between back-to-back requests.
  task automatic send_text(input logic [7:0] b, input logic eob);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.in_byte       <= b;
    in_ch.end_of_buffer <= eob;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    decode_byte(b, eob);
    bytes_sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CH_ZERO + 8'(n);
    if ($urandom_range(1)) return CH_UC_A + 8'(n) - 8'd10;
    return CH_LC_A + 8'(n) - 8'd10;
  endfunction

  // \uXXXX; eob_at marks the hex position that ends the buffer (4 = none)
  task automatic send_uhex(input logic [15:0] v, input int eob_at);
    send_text(CH_BSLASH, 1'b0);
    send_text(CH_LC_U, 1'b0);
    for (int i = 0; i < 4; i++) begin
      send_text(hex_char(v[15 - 4 * i -: 4]), i == eob_at);
      if (i == eob_at) return;
    end
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [15:0] pick_bmp();
    case ($urandom_range(5))
      0: return 16'($urandom_range(16'h7F));
      1: return 16'($urandom_range(16'h7FF, 16'h80));
      2: return 16'($urandom_range(16'hD7FF, 16'h800));
      3: return 16'($urandom_range(16'hFFFF, 16'hE000));
      4: return 16'($urandom_range(SURR_LO_MAX, SURR_LO_MIN));
      default: begin
        case ($urandom_range(5))
          0: return 16'h0000;
          1: return 16'hFFFF;
          2: return SURR_HI_MIN;
          3: return SURR_HI_MAX;
          4: return SURR_LO_MIN;
          default: return SURR_LO_MAX;
        endcase
      end
    endcase
  endfunction

  function automatic logic [15:0] pick_high();
    return 16'($urandom_range(SURR_HI_MAX, SURR_HI_MIN));
  endfunction

  task automatic send_escape_any();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CH_LC_U);
    send_text(CH_BSLASH, 1'b0);
    send_text(b, 1'b0);
  endtask

  task automatic send_token();
    logic [7:0] sel;
    int k;
    k = $urandom_range(99);
    if (k < 30) begin
      send_text(plain_char(), 1'b0);
    end else if (k < 42) begin
      case ($urandom_range(4))
        0: sel = CH_LC_N;
        1: sel = CH_LC_R;
        2: sel = CH_LC_T;
        3: sel = CH_LC_B;
        default: sel = CH_LC_F;
      endcase
      send_text(CH_BSLASH, 1'b0);
      send_text(sel, 1'b0);
    end else if (k < 50) begin
      send_escape_any();
    end else if (k < 68) begin
      send_uhex(pick_bmp(), 4);
    end else if (k < 82) begin
      send_uhex(pick_high(), 4);
      send_uhex(16'($urandom_range(SURR_LO_MAX, SURR_LO_MIN)), 4);
    end else if (k < 92) begin
      // high surrogate whose partner never comes
      send_uhex(pick_high(), 4);
      case ($urandom_range(3))
        0: send_text(plain_char(), 1'b0);
        1: send_escape_any();
        2: send_uhex(pick_bmp(), 4);
        default: send_uhex(pick_high(), 4);
      endcase
    end else begin
      // broken hex group: leading digits then anything
      send_text(CH_BSLASH, 1'b0);
      send_text(CH_LC_U, 1'b0);
      for (int i = 0; i < 4; i++) begin
        if ($urandom_range(1)) send_text(hex_char(4'($urandom_range(15))), 1'b0);
        else send_text(8'($urandom_range(255)), 1'b0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_basic_escapes();
    logic [7:0] esc_set [5];
    esc_set = '{CH_LC_N, CH_LC_R, CH_LC_T, CH_LC_B, CH_LC_F};
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b0);
    foreach (esc_set[i]) begin
      send_text(CH_BSLASH, 1'b0);
      send_text(esc_set[i], 1'b0);
    end
    send_text(CH_BSLASH, 1'b0);
    send_text(CH_QUOTE, 1'b0);  // escaped quote does not close
  endtask

  task automatic test_surrogate_pair();
    send_uhex(16'hD83D, 4);
    send_uhex(16'hDE00, 4);
  endtask

  task automatic test_random_text();
    src_idle_pct = 25;
    snk_idle_pct = 58;
    while (bytes_sent < 100) send_token();
    src_idle_pct = 58;
    snk_idle_pct = 25;
    while (bytes_sent < 170) send_token();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    while (bytes_sent < 240) send_token();
  endtask

  // Only one close per run, so the way the string ends is drawn at random
  task automatic test_string_end();
    case ($urandom_range(9))
      0: send_text(CH_QUOTE, 1'b0);
      1: send_text(CH_QUOTE, 1'b1);
      2: send_text(plain_char(), 1'b1);
      3: send_text(CH_BSLASH, 1'b1);
      4: send_uhex(pick_bmp(), $urandom_range(3));
      5: send_uhex(pick_high(), 3);
      6: begin
        send_uhex(pick_high(), 4);
        send_text(CH_BSLASH, 1'b1);
      end
      7: begin
        send_uhex(pick_high(), 4);
        send_uhex(16'($urandom_range(SURR_LO_MAX, SURR_LO_MIN)), $urandom_range(2));
      end
      8: begin
        send_uhex(pick_high(), 4);
        send_text(CH_QUOTE, 1'b0);
      end
      default: begin
        send_uhex(pick_high(), 4);
        send_uhex(16'($urandom_range(SURR_LO_MAX, SURR_LO_MIN)), 3);
      end
    endcase
  endtask

  task automatic test_after_close();
    send_text(CH_QUOTE, 1'b0);
    for (int i = 0; i < 6; i++) send_text(8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.in_byte       <= '0;
    in_ch.end_of_buffer <= 1'b0;
    dec_mode   = MODE_NORMAL;
    hex_val    = '0;
    hex_pos    = '0;
    hex_dead   = 1'b0;
    held_high  = '0;
    str_closed = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_basic_escapes();
    test_surrogate_pair();
    test_random_text();
    test_string_end();
    test_after_close();
    in_ch.valid <= 1'b0;

    while (due_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_bytes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/jsu_pkg.sv
design/jsu_in_if.sv
design/jsu_out_if.sv
design/json_string_unescape_utf8.sv
design/jsu_checker.sv
verif/tb.sv
